[rtl/point_to_polyline_nearest_top_macros.svh]
// Assertion macros for the polyline nearest-point block.
// Used by point_to_polyline_nearest_top; relies on clk_i and rst_ni in scope.
`ifndef POINT_TO_POLYLINE_NEAREST_TOP_MACROS_SVH
`define POINT_TO_POLYLINE_NEAREST_TOP_MACROS_SVH

// same-cycle implication
`define PPN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppn assertion failed");

// next-cycle implication
`define PPN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppn assertion failed");

`endif

[rtl/ppn_pkg.sv]
// Shared constants for the polyline nearest-point block.
// No dependencies.
package ppn_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int TOL_WIDTH     = 16;
  localparam int CFG_IDX_WIDTH = 3;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_QUERY_X   = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_QUERY_Y   = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TOLERANCE = 3'd3;

endpackage

[rtl/point_to_polyline_nearest_top.sv]
// Top level: nearest point of a streamed polyline to a configured query point.
// Depends on ppn_pkg, ppn_mul, ppn_div, ppn_sqrt and the assertion macro header.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+--------------------------------
//  in      | sink      | in_valid_i / in_stall_o   | vertex x, y, last flag
//  out     | source    | out_valid_o / out_stall_i | distance, nearest x, y, flags
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | register index, data
//
// Sequence: the first vertex of a polyline only passes through the finish state. A later
//   vertex runs 6 multiplies and a square root, with 2 more multiplies and 2 divisions
//   when it projects inside the segment.
// Reset: asynchronous, active low; no clearing pass, state is plain registers.
// Stalls: a finished result sits in the output register; the next vertex is taken
//   meanwhile and only a later last vertex waits for the register to drain.
`include "point_to_polyline_nearest_top_macros.svh"

module point_to_polyline_nearest_top #(
  parameter int COORD_WIDTH = ppn_pkg::COORD_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // vertex words
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]      in_vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0]      in_vertex_y_i,
  input  logic                               in_last_vertex_i,
  // result words
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [COORD_WIDTH:0]               out_min_distance_o,
  output logic signed [COORD_WIDTH-1:0]      out_nearest_x_o,
  output logic signed [COORD_WIDTH-1:0]      out_nearest_y_o,
  output logic                               out_within_radius_o,
  output logic                               out_no_segment_o,
  // register writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ppn_pkg::CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [COORD_WIDTH-1:0]             cfg_data_i
);
  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;        // coordinate differences, distance
  localparam int PW = 2 * DW + 1;   // dot product, squared length
  localparam int NW = PW + DW;      // projection numerator
  localparam int RW = (PW + 1) / 2; // square root result
  localparam int TW = ppn_pkg::TOL_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [2:0] OP_WXDX = 3'd0;
  localparam logic [2:0] OP_WYDY = 3'd1;
  localparam logic [2:0] OP_DXDX = 3'd2;
  localparam logic [2:0] OP_DYDY = 3'd3;
  localparam logic [2:0] OP_NX   = 3'd4;
  localparam logic [2:0] OP_NY   = 3'd5;
  localparam logic [2:0] OP_EXEX = 3'd6;
  localparam logic [2:0] OP_EYEY = 3'd7;

  // configuration
  logic [W-1:0]  qx_q, qy_q, radius_q;
  logic [TW-1:0] tol_q;

  // per-polyline state: A is the previous vertex, B the current one
  logic [W-1:0]  ax_q, ay_q, bx_q, by_q;
  logic          last_q, have_q, found_q;
  logic [DW-1:0] best_d_q;
  logic [W-1:0]  best_x_q, best_y_q;

  // sequencer and datapath registers
  logic [2:0]    state_q, state_d;
  logic [2:0]    op_q;
  logic          axis_q;
  logic          mul_go_q, div_go_q, sq_go_q;
  logic [PW-1:0] acc_q, dot_q, len2_q;
  logic [NW-1:0] num_q;
  logic [W-1:0]  nx_q, ny_q;

  // result register
  logic          out_valid_q;
  logic [DW-1:0] out_d_q;
  logic [W-1:0]  out_x_q, out_y_q;
  logic          out_wr_q, out_ns_q;

  logic [DW-1:0] dx, dy, wx, wy, ex, ey;
  logic [PW-1:0] mul_a;
  logic [DW-1:0] mul_b;
  logic          mul_done, div_done, sq_done;
  logic [NW-1:0] mul_p, div_q, num_mag, q_rnd, off;
  logic [PW-1:0] div_r, sum_p;
  logic [PW:0]   r_twice;
  logic [W-1:0]  n_new;
  logic [RW-1:0] root;
  logic          in_acc, out_free, dot_le0, dot_ge;
  logic [DW-1:0] rad_ext, rdiff;
  logic          in_radius;

  assign dx = {bx_q[W-1], bx_q} - {ax_q[W-1], ax_q};
  assign dy = {by_q[W-1], by_q} - {ay_q[W-1], ay_q};
  assign wx = {qx_q[W-1], qx_q} - {ax_q[W-1], ax_q};
  assign wy = {qy_q[W-1], qy_q} - {ay_q[W-1], ay_q};
  assign ex = {qx_q[W-1], qx_q} - {nx_q[W-1], nx_q};
  assign ey = {qy_q[W-1], qy_q} - {ny_q[W-1], ny_q};

  // operand select for the shared multiplier
  always_comb begin
    mul_a = {{(PW-DW){wx[DW-1]}}, wx};
    mul_b = dx;
    case (op_q)
      OP_WXDX: begin mul_a = {{(PW-DW){wx[DW-1]}}, wx}; mul_b = dx; end
      OP_WYDY: begin mul_a = {{(PW-DW){wy[DW-1]}}, wy}; mul_b = dy; end
      OP_DXDX: begin mul_a = {{(PW-DW){dx[DW-1]}}, dx}; mul_b = dx; end
      OP_DYDY: begin mul_a = {{(PW-DW){dy[DW-1]}}, dy}; mul_b = dy; end
      OP_NX:   begin mul_a = dot_q; mul_b = dx; end
      OP_NY:   begin mul_a = dot_q; mul_b = dy; end
      OP_EXEX: begin mul_a = {{(PW-DW){ex[DW-1]}}, ex}; mul_b = ex; end
      default: begin mul_a = {{(PW-DW){ey[DW-1]}}, ey}; mul_b = ey; end
    endcase
  end

  ppn_mul #(.AW(PW), .BW(DW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign num_mag = num_q[NW-1] ? (~num_q + NW'(1)) : num_q;

  ppn_div #(.NW(NW), .DW(PW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (num_mag),
    .den_i   (len2_q),
    .done_o  (div_done),
    .quo_o   (div_q),
    .rem_o   (div_r)
  );

  ppn_sqrt #(.SW(PW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_go_q),
    .s_i     (acc_q),
    .done_o  (sq_done),
    .root_o  (root)
  );

  // sum of the held product and the one just finished
  assign sum_p = acc_q + mul_p[PW-1:0];

  // projection outcome, checked once the squared length is known
  assign dot_le0 = dot_q[PW-1] || (dot_q == '0);
  assign dot_ge  = !dot_q[PW-1] && (dot_q >= sum_p);

  // round half away from zero, then add to the start vertex
  assign r_twice = {div_r, 1'b0};
  assign q_rnd   = (r_twice >= {1'b0, len2_q}) ? (div_q + NW'(1)) : div_q;
  assign off     = num_q[NW-1] ? (~q_rnd + NW'(1)) : q_rnd;
  assign n_new   = (axis_q ? ay_q : ax_q) + off[W-1:0];

  // radius test on the kept distance
  assign rad_ext   = {1'b0, radius_q};
  assign rdiff     = (best_d_q >= rad_ext) ? (best_d_q - rad_ext) : (rad_ext - best_d_q);
  assign in_radius = (best_d_q < rad_ext) || (rdiff < DW'(tol_q));

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = have_q ? S_MUL : S_FIN;
      S_MUL:   begin
        if (mul_done) begin
          if (op_q == OP_NX || op_q == OP_NY) state_d = S_DIV;
          else if (op_q == OP_EYEY) state_d = S_SQRT;
        end
      end
      S_DIV:   if (div_done) state_d = S_MUL;
      S_SQRT:  if (sq_done) state_d = S_FIN;
      S_FIN:   if (!last_q || out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      qx_q        <= '0;
      qy_q        <= '0;
      radius_q    <= '0;
      tol_q       <= TW'(1);
      ax_q        <= '0;
      ay_q        <= '0;
      bx_q        <= '0;
      by_q        <= '0;
      last_q      <= 1'b0;
      have_q      <= 1'b0;
      found_q     <= 1'b0;
      best_d_q    <= '1;
      best_x_q    <= '0;
      best_y_q    <= '0;
      op_q        <= OP_WXDX;
      axis_q      <= 1'b0;
      mul_go_q    <= 1'b0;
      div_go_q    <= 1'b0;
      sq_go_q     <= 1'b0;
      acc_q       <= '0;
      dot_q       <= '0;
      len2_q      <= '0;
      num_q       <= '0;
      nx_q        <= '0;
      ny_q        <= '0;
      out_valid_q <= 1'b0;
      out_d_q     <= '0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_wr_q    <= 1'b0;
      out_ns_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
      sq_go_q  <= 1'b0;

      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          ppn_pkg::CFG_QUERY_X:   qx_q     <= cfg_data_i;
          ppn_pkg::CFG_QUERY_Y:   qy_q     <= cfg_data_i;
          ppn_pkg::CFG_RADIUS:    radius_q <= cfg_data_i;
          ppn_pkg::CFG_TOLERANCE: tol_q    <= cfg_data_i[TW-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            bx_q   <= in_vertex_x_i;
            by_q   <= in_vertex_y_i;
            last_q <= in_last_vertex_i;
            op_q   <= OP_WXDX;
            if (have_q) mul_go_q <= 1'b1;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            case (op_q)
              OP_WXDX: begin acc_q <= mul_p[PW-1:0]; op_q <= OP_WYDY; mul_go_q <= 1'b1; end
              OP_WYDY: begin dot_q <= sum_p; op_q <= OP_DXDX; mul_go_q <= 1'b1; end
              OP_DXDX: begin acc_q <= mul_p[PW-1:0]; op_q <= OP_DYDY; mul_go_q <= 1'b1; end
              OP_DYDY: begin
                len2_q   <= sum_p;
                mul_go_q <= 1'b1;
                if (dot_le0) begin
                  nx_q <= ax_q;
                  ny_q <= ay_q;
                  op_q <= OP_EXEX;
                end else if (dot_ge) begin
                  nx_q <= bx_q;
                  ny_q <= by_q;
                  op_q <= OP_EXEX;
                end else begin
                  op_q <= OP_NX;
                end
              end
              OP_NX:   begin num_q <= mul_p; axis_q <= 1'b0; div_go_q <= 1'b1; end
              OP_NY:   begin num_q <= mul_p; axis_q <= 1'b1; div_go_q <= 1'b1; end
              OP_EXEX: begin acc_q <= mul_p[PW-1:0]; op_q <= OP_EYEY; mul_go_q <= 1'b1; end
              default: begin acc_q <= sum_p; sq_go_q <= 1'b1; end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            mul_go_q <= 1'b1;
            if (axis_q) begin
              ny_q <= n_new;
              op_q <= OP_EXEX;
            end else begin
              nx_q <= n_new;
              op_q <= OP_NY;
            end
          end
        end
        S_SQRT: begin
          // strict compare: ties keep the earlier segment
          if (sq_done && (!found_q || root[DW-1:0] < best_d_q)) begin
            best_d_q <= root[DW-1:0];
            best_x_q <= nx_q;
            best_y_q <= ny_q;
            found_q  <= 1'b1;
          end
        end
        S_FIN: begin
          if (!last_q) begin
            ax_q   <= bx_q;
            ay_q   <= by_q;
            have_q <= 1'b1;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_ns_q    <= !found_q;
            out_d_q     <= found_q ? best_d_q : '0;
            out_x_q     <= found_q ? best_x_q : '0;
            out_y_q     <= found_q ? best_y_q : '0;
            out_wr_q    <= found_q && in_radius;
            ax_q        <= '0;
            ay_q        <= '0;
            have_q      <= 1'b0;
            found_q     <= 1'b0;
            best_d_q    <= '1;
            best_x_q    <= '0;
            best_y_q    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_stall_o          = (state_q != S_IDLE);
  assign cfg_ready_o         = 1'b1;
  assign out_valid_o         = out_valid_q;
  assign out_min_distance_o  = out_d_q;
  assign out_nearest_x_o     = out_x_q;
  assign out_nearest_y_o     = out_y_q;
  assign out_within_radius_o = out_wr_q;
  assign out_no_segment_o    = out_ns_q;

  // a kept segment needs a vertex before it
  `PPN_ASSERT_NOW(a_found_has_prev, found_q, have_q)
  // an empty polyline reports zeros only
  `PPN_ASSERT_NOW(a_empty_zero, out_valid_o && out_no_segment_o,
                  out_min_distance_o == '0 && !out_within_radius_o)
  // a taken vertex always moves the sequencer out of idle, which stalls the input
  `PPN_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o)
  // at most one unit is started at a time by the sequencer
  `PPN_ASSERT_NOW(a_one_start, mul_go_q || div_go_q || sq_go_q,
                  $onehot({mul_go_q, div_go_q, sq_go_q}))

endmodule

[rtl/ppn_mul.sv]
// Bit-serial signed multiplier: one multiplier bit per cycle.
// Depends on nothing; parameters come from the top level.
module ppn_mul #(
  parameter int AW = 67,
  parameter int BW = 33
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [AW-1:0]        a_i,
  input  logic [BW-1:0]        b_i,
  output logic                 done_o,
  output logic [AW+BW-1:0]     p_o
);
  localparam int CW = (BW > 1) ? $clog2(BW) : 1;

  logic [AW+BW-1:0] acc_q, ash_q;
  logic [BW-1:0]    bm_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, neg_q, done_q;
  logic [BW-1:0]    b_mag;

  assign b_mag = b_i[BW-1] ? (~b_i + BW'(1)) : b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      acc_q  <= '0;
      ash_q  <= '0;
      bm_q   <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        acc_q  <= '0;
        ash_q  <= {{BW{a_i[AW-1]}}, a_i};
        bm_q   <= b_mag;
        neg_q  <= b_i[BW-1];
        cnt_q  <= CW'(BW - 1);
      end else if (busy_q) begin
        if (bm_q[0]) acc_q <= acc_q + ash_q;
        ash_q <= {ash_q[AW+BW-2:0], 1'b0};
        bm_q  <= {1'b0, bm_q[BW-1:1]};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = neg_q ? (~acc_q + (AW+BW)'(1)) : acc_q;

endmodule

[rtl/ppn_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on nothing; parameters come from the top level.
module ppn_div #(
  parameter int NW = 100,
  parameter int DW = 67
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);
  localparam int CW = $clog2(NW);

  logic [NW-1:0] n_q, q_q;
  logic [DW-1:0] r_q, d_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   trial, diff;
  logic          ge;

  assign trial = {r_q, n_q[NW-1]};
  assign ge    = trial >= {1'b0, d_q};
  assign diff  = trial - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      n_q    <= '0;
      q_q    <= '0;
      r_q    <= '0;
      d_q    <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        n_q    <= num_i;
        d_q    <= den_i;
        r_q    <= '0;
        q_q    <= '0;
        cnt_q  <= CW'(NW - 1);
      end else if (busy_q) begin
        r_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
        q_q <= {q_q[NW-2:0], ge};
        n_q <= {n_q[NW-2:0], 1'b0};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
  assign rem_o  = r_q;

endmodule

[rtl/ppn_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on nothing; parameters come from the top level.
module ppn_sqrt #(
  parameter int SW = 67
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SW-1:0]      s_i,
  output logic               done_o,
  output logic [(SW+1)/2-1:0] root_o
);
  localparam int RW = (SW + 1) / 2;
  localparam int PW = 2 * RW;
  localparam int CW = (RW > 1) ? $clog2(RW) : 1;

  logic [PW-1:0]   s_q;
  logic [RW+1:0]   rem_q;
  logic [RW-1:0]   root_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q, done_q;
  logic [RW+3:0]   t, trial, diff;
  logic            ge;

  assign t     = {rem_q, s_q[PW-1:PW-2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = t >= trial;
  assign diff  = t - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      s_q    <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        s_q    <= PW'(s_i);
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= CW'(RW - 1);
      end else if (busy_q) begin
        rem_q  <= ge ? diff[RW+1:0] : t[RW+1:0];
        root_q <= {root_q[RW-2:0], ge};
        s_q    <= {s_q[PW-3:0], 2'b00};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
